>>> rtl/vector_moving_average_unit_assert.svh
// ---------------------------------------------------------------------------
// vector moving average assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef VECTOR_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define VECTOR_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication
`define VMA_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VMA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vma_pkg.sv
// ---------------------------------------------------------------------------
// vma_pkg
// shared constants, register codes and result type of the moving average unit
// ---------------------------------------------------------------------------
package vma_pkg;

  localparam int MAX_WINDOW_DEF   = 256;
  localparam int MAX_LANES_DEF    = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int OUT_W      = 24;
  localparam int LANE_OUT_W = 6;
  localparam int TUSER_W    = LANE_OUT_W + 1;

  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 12;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'h1000;

  localparam int WIN_CFG_W  = 9;
  localparam int VEC_CFG_W  = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_LENGTH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic                  saturated;
    logic [LANE_OUT_W-1:0] lane;
    logic [OUT_W-1:0]      average;
  } vma_result_t;

endpackage

>>> rtl/vma_ram.sv
// ---------------------------------------------------------------------------
// vma_ram
// simple dual-port ram, one write and one registered read port, read-first
// ---------------------------------------------------------------------------
module vma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/vma_scale.sv
// ---------------------------------------------------------------------------
// vma_scale
// q4.12 gain on the window sum, round half up, saturate to the output width
// ---------------------------------------------------------------------------
module vma_scale #(
  parameter int SUM_W  = 24,
  parameter int LANE_W = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sum_valid,
  input  logic signed [SUM_W-1:0]       sum,
  input  logic [LANE_W-1:0]             lane,
  input  logic [vma_pkg::SCALE_W-1:0]   gain,
  output logic                          res_valid,
  output vma_pkg::vma_result_t          res
);

  localparam int PROD_W = SUM_W + vma_pkg::SCALE_W + 1;
  localparam int SH_W   = PROD_W - vma_pkg::FRAC_W;
  localparam int CMP_W  = ((SH_W > vma_pkg::OUT_W) ? SH_W : vma_pkg::OUT_W) + 1;
  localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'((1 << (vma_pkg::OUT_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [PROD_W-1:0] sum_x;
  logic signed [PROD_W-1:0] gain_x;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [LANE_W-1:0]        lane_r;
  logic                     valid_r;
  logic [PROD_W-1:0]        rnd;
  logic [SH_W-1:0]          sh;
  logic signed [CMP_W-1:0]  shx;

  assign sum_x    = {{(vma_pkg::SCALE_W + 1){sum[SUM_W-1]}}, sum};
  assign gain_x   = {{(SUM_W + 1){1'b0}}, gain};
  assign prod_nxt = sum_x * gain_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      prod_r <= prod_nxt;
      lane_r <= lane;
    end
  end

  // floor((prod + half) / 4096)
  assign rnd = prod_r + PROD_W'(vma_pkg::ROUND_HALF);
  assign sh  = rnd[PROD_W-1:vma_pkg::FRAC_W];
  assign shx = {{(CMP_W - SH_W){sh[SH_W-1]}}, sh};

  always_comb begin
    res.lane = vma_pkg::LANE_OUT_W'(lane_r);
    priority if (shx > SAT_HI) begin
      res.average   = SAT_HI[vma_pkg::OUT_W-1:0];
      res.saturated = 1'b1;
    end else if (shx < SAT_LO) begin
      res.average   = SAT_LO[vma_pkg::OUT_W-1:0];
      res.saturated = 1'b1;
    end else begin
      res.average   = shx[vma_pkg::OUT_W-1:0];
      res.saturated = 1'b0;
    end
  end

  assign res_valid = valid_r;

endmodule

>>> rtl/vma_out_fifo.sv
// ---------------------------------------------------------------------------
// vma_out_fifo
// result queue that decouples the fixed-latency datapath from out_tready
// ---------------------------------------------------------------------------
`include "vector_moving_average_unit_assert.svh"

module vma_out_fifo #(
  parameter int DEPTH = vma_pkg::FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  vma_pkg::vma_result_t       push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output vma_pkg::vma_result_t       head,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  vma_pkg::vma_result_t mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [PTR_W-1:0]     wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_nxt;
  logic [LVL_W-1:0]     level_r;
  logic [LVL_W-1:0]     level_nxt;
  logic                 pop_fire;

  assign head_valid = (level_r != '0);
  assign pop_fire   = pop && head_valid;
  assign head       = mem_r[rd_ptr_r];
  assign level      = level_r;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  always_comb begin
    unique case ({push, pop_fire})
      2'b10:   level_nxt = level_r + LVL_W'(1);
      2'b01:   level_nxt = level_r - LVL_W'(1);
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `VMA_ASSERT_IMPLY(a_fifo_no_overflow, (push && !pop_fire), (level_r < LVL_W'(DEPTH)), "result queue overflow")
  `VMA_ASSERT_NEXT(a_fifo_push_visible, push, head_valid, "pushed item not visible at head")

endmodule

>>> rtl/vector_moving_average_unit.sv
// ---------------------------------------------------------------------------
// vector_moving_average_unit
// per-lane moving window sum over interleaved vectors, scaled and saturated
// ---------------------------------------------------------------------------
// path: input accept to out_tvalid through ram read, sum update, multiply,
//   round/saturate into the result queue; throughput: one item per clock
//   while result queue credit is left; the history and lane-sum rams run one
//   read-modify-write per cycle with a one-entry bypass for back-to-back hits
// reset: synchronous, active low; counters and config go to defaults, stale
//   ram contents read as zero until the window has been filled once, no
//   clearing pass; window or vector length writes restart the same way
// ---------------------------------------------------------------------------
`include "vector_moving_average_unit_assert.svh"

module vector_moving_average_unit #(
  parameter int MAX_WINDOW   = vma_pkg::MAX_WINDOW_DEF,
  parameter int MAX_LANES    = vma_pkg::MAX_LANES_DEF,
  parameter int SAMPLE_WIDTH = vma_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [SAMPLE_WIDTH-1:0] sample, zero padded to whole bytes
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata: [23:0] average
  // out_tuser: [5:0] lane, [6] saturated
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vma_pkg::OUT_W-1:0]         out_tdata,
  output logic [vma_pkg::TUSER_W-1:0]       out_tuser,
  input  logic                              cfg_we,
  input  logic [vma_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [vma_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int LANE_W  = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int WL_W    = $clog2(MAX_WINDOW + 1);
  localparam int VL_W    = $clog2(MAX_LANES + 1);
  localparam int HIST_AW = SLOT_W + LANE_W;
  localparam int SUM_W   = SAMPLE_WIDTH + SLOT_W;
  localparam int LVL_W   = $clog2(vma_pkg::FIFO_DEPTH + 1);
  localparam int CRED_W  = LVL_W + 1;

  // configuration and position state
  logic [WL_W-1:0]             win_len_r;
  logic [VL_W-1:0]             vec_len_r;
  logic [vma_pkg::SCALE_W-1:0] scale_r;
  logic [LANE_W-1:0]           lane_r;
  logic [SLOT_W-1:0]           slot_r;
  logic                        full_r;
  logic                        run_r;

  logic [vma_pkg::WIN_CFG_W-1:0] wl_raw;
  logic [vma_pkg::VEC_CFG_W-1:0] vl_raw;
  logic [WL_W-1:0]               wl_clamp;
  logic [VL_W-1:0]               vl_clamp;

  logic              in_acc;
  logic [VL_W-1:0]   lane_inc;
  logic [WL_W-1:0]   slot_inc;
  logic              lane_wrap;
  logic              slot_wrap;
  logic [LANE_W-1:0] lane_nxt;
  logic [SLOT_W-1:0] slot_nxt;
  logic              full_nxt;

  // ram read stage
  logic                           b_valid_r;
  logic [HIST_AW-1:0]             b_addr_r;
  logic signed [SAMPLE_WIDTH-1:0] b_sample_r;
  logic                           b_hist_zero_r;
  logic                           b_sum_zero_r;
  logic [LANE_W-1:0]              b_lane;
  logic signed [SAMPLE_WIDTH-1:0] hist_rdata;
  logic signed [SUM_W-1:0]        sum_rdata;
  logic signed [SAMPLE_WIDTH-1:0] hist_old;
  logic signed [SUM_W-1:0]        sum_old;
  logic signed [SUM_W-1:0]        sum_nxt;

  // sum stage
  logic                           c_valid_r;
  logic [HIST_AW-1:0]             c_addr_r;
  logic signed [SAMPLE_WIDTH-1:0] c_sample_r;
  logic signed [SUM_W-1:0]        c_sum_r;
  logic [LANE_W-1:0]              c_lane;

  logic                 res_valid;
  vma_pkg::vma_result_t res;
  vma_pkg::vma_result_t out_res;
  logic [LVL_W-1:0]     fifo_level;
  logic [CRED_W-1:0]    credit;

  // register clamping
  assign wl_raw = cfg_wdata[vma_pkg::WIN_CFG_W-1:0];
  assign vl_raw = cfg_wdata[vma_pkg::VEC_CFG_W-1:0];

  always_comb begin
    priority if (wl_raw == '0) begin
      wl_clamp = WL_W'(1);
    end else if (32'(wl_raw) > MAX_WINDOW) begin
      wl_clamp = WL_W'(MAX_WINDOW);
    end else begin
      wl_clamp = WL_W'(wl_raw);
    end
    priority if (vl_raw == '0) begin
      vl_clamp = VL_W'(1);
    end else if (32'(vl_raw) > MAX_LANES) begin
      vl_clamp = VL_W'(MAX_LANES);
    end else begin
      vl_clamp = VL_W'(vl_raw);
    end
  end

  // position counters
  assign in_acc    = in_tvalid && in_tready;
  assign lane_inc  = VL_W'(lane_r) + VL_W'(1);
  assign slot_inc  = WL_W'(slot_r) + WL_W'(1);
  assign lane_wrap = (lane_inc >= vec_len_r);
  assign slot_wrap = (slot_inc >= win_len_r);
  assign lane_nxt  = lane_wrap ? '0 : lane_inc[LANE_W-1:0];
  assign slot_nxt  = lane_wrap ? (slot_wrap ? '0 : slot_inc[SLOT_W-1:0]) : slot_r;
  assign full_nxt  = full_r | (lane_wrap & slot_wrap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WL_W'(1);
      vec_len_r <= VL_W'(1);
      scale_r   <= vma_pkg::SCALE_RESET;
      lane_r    <= '0;
      slot_r    <= '0;
      full_r    <= 1'b0;
      run_r     <= 1'b0;
    end else begin
      run_r <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_addr)
          vma_pkg::REG_WINDOW_LENGTH: begin
            win_len_r <= wl_clamp;
            lane_r    <= '0;
            slot_r    <= '0;
            full_r    <= 1'b0;
          end
          vma_pkg::REG_VECTOR_LENGTH: begin
            vec_len_r <= vl_clamp;
            lane_r    <= '0;
            slot_r    <= '0;
            full_r    <= 1'b0;
          end
          vma_pkg::REG_SCALE_FACTOR: begin
            scale_r <= cfg_wdata[vma_pkg::SCALE_W-1:0];
          end
          default: begin
          end
        endcase
      end else if (in_acc) begin
        lane_r <= lane_nxt;
        slot_r <= slot_nxt;
        full_r <= full_nxt;
      end
    end
  end

  // history and lane sums
  vma_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (2 ** HIST_AW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_addr_r),
    .wdata (b_sample_r),
    .raddr ({slot_r, lane_r}),
    .rdata (hist_rdata)
  );

  vma_ram #(
    .WIDTH (SUM_W),
    .DEPTH (2 ** LANE_W)
  ) u_sum_ram (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_lane),
    .wdata (sum_nxt),
    .raddr (lane_r),
    .rdata (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      b_valid_r <= in_acc;
      c_valid_r <= b_valid_r;
    end
  end

  // first pass through the window: history entries are still unwritten,
  // and in slot zero of it each lane sum is too
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_addr_r      <= {slot_r, lane_r};
      b_sample_r    <= in_tdata[SAMPLE_WIDTH-1:0];
      b_hist_zero_r <= !full_r;
      b_sum_zero_r  <= !full_r && (slot_r == '0);
    end
    if (b_valid_r) begin
      c_addr_r   <= b_addr_r;
      c_sample_r <= b_sample_r;
      c_sum_r    <= sum_nxt;
    end
  end

  assign b_lane = b_addr_r[LANE_W-1:0];
  assign c_lane = c_addr_r[LANE_W-1:0];

  // bypass the write made in the same cycle as this item's ram read
  always_comb begin
    priority if (b_hist_zero_r) begin
      hist_old = '0;
    end else if (c_valid_r && (c_addr_r == b_addr_r)) begin
      hist_old = c_sample_r;
    end else begin
      hist_old = hist_rdata;
    end
    priority if (b_sum_zero_r) begin
      sum_old = '0;
    end else if (c_valid_r && (c_lane == b_lane)) begin
      sum_old = c_sum_r;
    end else begin
      sum_old = sum_rdata;
    end
  end

  assign sum_nxt = sum_old
                 - {{SLOT_W{hist_old[SAMPLE_WIDTH-1]}}, hist_old}
                 + {{SLOT_W{b_sample_r[SAMPLE_WIDTH-1]}}, b_sample_r};

  vma_scale #(
    .SUM_W  (SUM_W),
    .LANE_W (LANE_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (c_valid_r),
    .sum       (c_sum_r),
    .lane      (c_lane),
    .gain      (scale_r),
    .res_valid (res_valid),
    .res       (res)
  );

  vma_out_fifo #(
    .DEPTH (vma_pkg::FIFO_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head       (out_res),
    .level      (fifo_level)
  );

  // every item in flight has a queue slot reserved
  assign credit = CRED_W'(fifo_level) + CRED_W'(b_valid_r) + CRED_W'(c_valid_r)
                + CRED_W'(res_valid);
  assign in_tready = run_r && (credit < CRED_W'(vma_pkg::FIFO_DEPTH));

  assign out_tdata = out_res.average;
  assign out_tuser = {out_res.saturated, out_res.lane};

  `VMA_ASSERT_IMPLY(a_lane_in_range, 1'b1, (VL_W'(lane_r) < vec_len_r), "lane counter past vector length")
  `VMA_ASSERT_IMPLY(a_slot_in_range, 1'b1, (WL_W'(slot_r) < win_len_r), "slot counter past window length")
  `VMA_ASSERT_IMPLY(a_result_has_item, res_valid, $past(in_acc, 3), "result without an accepted item")

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// stream test of the vector moving average unit: corner samples first, then
// directed length, gain and clipping cases, then phases of extreme and random
// geometry, gain and sample mix; each result is checked against a per-lane
// window sum predictor, both stream sides stalling at random unless no_idle
module tb;
  import vma_pkg::*;

  localparam int RANDOM_ITEMS  = 850;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PRINT_LIMIT   = 100;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  localparam longint AVG_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint AVG_MIN = -(longint'(1) <<< (OUT_W - 1));

  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_PUSH, MIX_SMALL} sample_mix_t;

  // per-lane window sums and the averages they should produce
  class lane_average_tracker;
    shortint          history [MAX_WINDOW_DEF * MAX_LANES_DEF];
    longint           lane_sums [MAX_LANES_DEF];
    int               lane_pos;
    int               slot_pos;
    int               win_len;
    int               vec_len;
    int               gain;
    int               mismatches;
    vma_result_t      expected_averages [$];

    function new();
      win_len    = 1;
      vec_len    = 1;
      gain       = int'(SCALE_RESET);
      mismatches = 0;
      clear_windows();
    endfunction

    function void clear_windows();
      foreach (history[i]) history[i] = 0;
      foreach (lane_sums[i]) lane_sums[i] = 0;
      lane_pos = 0;
      slot_pos = 0;
    endfunction

    function int fit_length(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_WINDOW_LENGTH: begin
          win_len = fit_length(int'(data[WIN_CFG_W-1:0]), MAX_WINDOW_DEF);
          clear_windows();
        end
        REG_VECTOR_LENGTH: begin
          vec_len = fit_length(int'(data[VEC_CFG_W-1:0]), MAX_LANES_DEF);
          clear_windows();
        end
        REG_SCALE_FACTOR: begin
          gain = int'(data[SCALE_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    function int waiting();
      return expected_averages.size();
    endfunction

    function void take_sample(logic [SAMPLE_WIDTH_DEF-1:0] raw);
      int          idx;
      longint      s;
      longint      total;
      longint      prod;
      longint      avg;
      vma_result_t r;
      idx = slot_pos * MAX_LANES_DEF + lane_pos;
      s = $signed(raw);
      total = lane_sums[lane_pos] - longint'(history[idx]) + s;
      history[idx] = shortint'(s);
      lane_sums[lane_pos] = total;
      // floor shift after the half offset rounds half toward plus infinity
      prod = total * longint'(gain);
      avg = (prod + ROUND_HALF) >>> FRAC_W;
      r.saturated = 1'b0;
      if (avg > AVG_MAX) begin
        avg = AVG_MAX;
        r.saturated = 1'b1;
      end
      if (avg < AVG_MIN) begin
        avg = AVG_MIN;
        r.saturated = 1'b1;
      end
      r.average = avg[OUT_W-1:0];
      r.lane    = lane_pos[LANE_OUT_W-1:0];
      expected_averages.push_back(r);
      lane_pos++;
      if (lane_pos >= vec_len) begin
        lane_pos = 0;
        slot_pos++;
        if (slot_pos >= win_len) slot_pos = 0;
      end
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    endfunction

    function void check_average(logic [OUT_W-1:0] data, logic [TUSER_W-1:0] user);
      vma_result_t got;
      vma_result_t want;
      got = {user, data};
      if (expected_averages.size() == 0) begin
        report_mismatch("item with nothing pending", longint'(got), 0);
      end else begin
        want = expected_averages.pop_front();
        if (got.average !== want.average)
          report_mismatch("average", $signed(got.average), $signed(want.average));
        if (got.lane !== want.lane)
          report_mismatch("lane", got.lane, want.lane);
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", got.saturated, want.saturated);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic [TUSER_W-1:0]    out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  lane_average_tracker   tracker;
  sample_mix_t           sample_mix    = MIX_FULL;
  bit                    push_negative = 1'b0;
  bit                    no_idle       = 1'b0;
  int                    idle_cycles;

  logic [15:0] corner_samples [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};

  vector_moving_average_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] next_sample();
    case (sample_mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      MIX_PUSH: begin
        // one sign near full scale, drives the sums into saturation
        if (push_negative) return 16'h8000 + 16'($urandom_range(0, 255));
        return 16'h7FFF - 16'($urandom_range(0, 255));
      end
      MIX_SMALL: return 16'($urandom_range(0, 15)) - 16'd8;
      default:   return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_window();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 1;
      2, 3, 4: v = $urandom_range(2, 8);
      5, 6:    v = $urandom_range(17, 40);
      7:       v = 256;
      8:       v = $urandom_range(257, 511);
      default: v = $urandom_range(9, 255);
    endcase
    // bits above the register width are don't care
    if ($urandom_range(0, 1)) return 16'(v) | (16'($urandom) & 16'hFE00);
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_vector();
    int v;
    case ($urandom_range(0, 9))
      0:          v = 0;
      1:          v = 1;
      2, 3, 4, 5: v = $urandom_range(2, 8);
      6:          v = 64;
      7:          v = $urandom_range(65, 127);
      default:    v = $urandom_range(9, 63);
    endcase
    if ($urandom_range(0, 1)) return 16'(v) | (16'($urandom) & 16'hFF80);
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return SCALE_RESET;
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom_range(1, 4095));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // all tasks below start and end on a falling edge
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_register(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [15:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.take_sample(s);
    @(negedge clk);
  endtask

  task automatic send_block(input int count);
    for (int i = 0; i < count; i++) send_sample(next_sample());
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    while (tracker.waiting() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      tracker.check_average(out_tdata, out_tuser);
  end

  initial begin : sink
    int hold;
    bit ready_now;
    hold = 0;
    ready_now = 1'b1;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        ready_now = 1'b1;
        hold = 0;
      end else if (hold == 0) begin
        ready_now = !ready_now;
        if (ready_now) hold = $urandom_range(1, 24);
        else if ($urandom_range(0, 9) < 8) hold = $urandom_range(1, 3);
        else hold = $urandom_range(15, 50);
      end
      if (hold > 0) hold--;
      out_tready <= ready_now;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int random_sent;
    int phase;
    int count;
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: window of one, one lane, unity gain
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    in_tvalid <= 1'b0;
    settle();

    // zero lengths read as one, unused index ignored, zero gain
    write_reg(REG_WINDOW_LENGTH, 16'h0000);
    write_reg(REG_VECTOR_LENGTH, 16'h0000);
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_SCALE_FACTOR, 16'h0000);
    for (int i = 0; i < 2; i++) send_sample(corner_samples[i]);
    in_tvalid <= 1'b0;
    settle();

    // full gain on a filling window of full-scale samples clips at the top
    write_reg(REG_WINDOW_LENGTH, 16'd17);
    write_reg(REG_VECTOR_LENGTH, 16'd1);
    write_reg(REG_SCALE_FACTOR, 16'hFFFF);
    for (int i = 0; i < 17; i++) send_sample(16'h7FFF);
    in_tvalid <= 1'b0;
    settle();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      sample_mix    = sample_mix_t'($urandom_range(0, 3));
      push_negative = $urandom_range(0, 1);
      no_idle       = ($urandom_range(0, 3) == 0);
      count         = $urandom_range(20, 80);
      if (phase == 0) begin
        // longest window on one lane, wrapped once
        write_reg(REG_WINDOW_LENGTH, 16'd256);
        write_reg(REG_VECTOR_LENGTH, 16'd1);
        write_reg(REG_SCALE_FACTOR, pick_scale());
        sample_mix = MIX_FULL;
        count = 260;
      end else if (phase == 1) begin
        // widest vector, short window, wrapped once
        write_reg(REG_VECTOR_LENGTH, 16'd64);
        write_reg(REG_WINDOW_LENGTH, 16'd2);
        write_reg(REG_SCALE_FACTOR, pick_scale());
        sample_mix = MIX_FULL;
        count = 200;
      end else if ($urandom_range(0, 4) == 0) begin
        // gain change alone keeps history and positions
        write_reg(REG_SCALE_FACTOR, pick_scale());
      end else begin
        write_reg(REG_WINDOW_LENGTH, pick_window());
        write_reg(REG_VECTOR_LENGTH, pick_vector());
        write_reg(REG_SCALE_FACTOR, pick_scale());
        if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 16'($urandom));
      end
      send_block(count);
      random_sent += count;
      phase++;
      settle();
      no_idle = 1'b0;
    end

    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
